### hdl/spin_structure_factor_defines.svh
// Assertion macros for the spin structure factor block.
`ifndef SPIN_STRUCTURE_FACTOR_DEFINES_SVH
`define SPIN_STRUCTURE_FACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spin_structure_factor: check failed");
`define SSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spin_structure_factor: check failed");
`else
`define SSF_ASSERT_NOW(lbl, ante, cons)
`define SSF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/ssf_pkg.sv
// Shared types, constants and functions of the spin structure factor block.
package ssf_pkg;

  localparam int unsigned LEN_W      = 7;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned SF_W       = 35;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned OUT_TDATA_W = ((3 * SF_W + 7) / 8) * 8;

  localparam logic [SF_W-1:0] SF_LIMIT  = 35'h4_0000_0000;
  localparam logic [16:0]     QTR_TURN  = 17'd65536;
  localparam logic [1:0]      LAST_COMP = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM    = 3'd0,
    CFG_LEN_X  = 3'd1,
    CFG_LEN_Y  = 3'd2,
    CFG_LEN_Z  = 3'd3,
    CFG_STEP_X = 3'd4,
    CFG_STEP_Y = 3'd5,
    CFG_STEP_Z = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_HORN, OP_FIN, OP_MAC, OP_ADV, OP_N1,
    OP_N2, OP_SQLL, OP_SQMID, OP_SQHH, OP_DIVI, OP_DIVS, OP_STORE, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] coef;
    logic       pass;
    logic [1:0] comp;
    logic       sel;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_busy;
  } sts_t;

  // Odd polynomial coefficients of the quarter sine, Q30.
  function automatic logic [31:0] poly_coef(input logic [2:0] idx);
    case (idx)
      3'd0:    return 32'd1686629713;
      3'd1:    return 32'd693598668;
      3'd2:    return 32'd85569274;
      3'd3:    return 32'd5026995;
      default: return 32'd172272;
    endcase
  endfunction

endpackage

### hdl/ssf_ctrl.sv
// Sequencer that steps the shared multiplier and divider through each site and lattice end.
module ssf_ctrl #(
  parameter int unsigned QW = 56
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssf_pkg::sts_t  sts_i,
  output ssf_pkg::cmd_t  cmd_o
);

  localparam int unsigned CNT_W = $clog2(QW);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_HORN, S_FIN, S_MAC, S_ADV, S_WAIT, S_N1, S_N2,
    S_SQ2, S_DIVI, S_DIV, S_STORE, S_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pass_q;
  logic [1:0]       comp_q;
  logic             sel_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.op   = ssf_pkg::OP_NONE;
    cmd_o.coef = cnt_q[2:0];
    cmd_o.pass = pass_q;
    cmd_o.comp = comp_q;
    cmd_o.sel  = sel_q;
    case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? ssf_pkg::OP_LOAD : ssf_pkg::OP_NONE;
      S_SQ:    cmd_o.op = ssf_pkg::OP_SQ;
      S_HORN:  cmd_o.op = ssf_pkg::OP_HORN;
      S_FIN:   cmd_o.op = ssf_pkg::OP_FIN;
      S_MAC:   cmd_o.op = ssf_pkg::OP_MAC;
      S_ADV:   cmd_o.op = ssf_pkg::OP_ADV;
      S_N1:    cmd_o.op = ssf_pkg::OP_N1;
      S_N2:    cmd_o.op = ssf_pkg::OP_N2;
      S_SQ2: begin
        if (cnt_q == CNT_W'(0)) cmd_o.op = ssf_pkg::OP_SQLL;
        else if (cnt_q == CNT_W'(1)) cmd_o.op = ssf_pkg::OP_SQMID;
        else cmd_o.op = ssf_pkg::OP_SQHH;
      end
      S_DIVI:  cmd_o.op = ssf_pkg::OP_DIVI;
      S_DIV:   cmd_o.op = ssf_pkg::OP_DIVS;
      S_STORE: cmd_o.op = ssf_pkg::OP_STORE;
      S_EMIT:  cmd_o.op = ssf_pkg::OP_EMIT;
      default: cmd_o.op = ssf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      comp_q  <= '0;
      sel_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pass_q  <= 1'b0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_q   <= CNT_W'(3);
          state_q <= S_HORN;
        end
        S_HORN: begin
          if (cnt_q == '0) state_q <= S_FIN;
          else cnt_q <= cnt_q - 1'b1;
        end
        S_FIN: begin
          if (!pass_q) begin
            pass_q  <= 1'b1;
            state_q <= S_SQ;
          end else begin
            comp_q  <= '0;
            sel_q   <= 1'b0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          sel_q <= ~sel_q;
          if (sel_q) begin
            if (comp_q == ssf_pkg::LAST_COMP) state_q <= S_ADV;
            else comp_q <= comp_q + 1'b1;
          end
        end
        S_ADV:   state_q <= sts_i.frame_end ? S_WAIT : S_IDLE;
        S_WAIT:  if (!sts_i.out_busy) state_q <= S_N1;
        S_N1:    state_q <= S_N2;
        S_N2: begin
          comp_q  <= '0;
          sel_q   <= 1'b0;
          cnt_q   <= '0;
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          if (cnt_q != CNT_W'(2)) begin
            cnt_q <= cnt_q + 1'b1;
          end else begin
            cnt_q <= '0;
            sel_q <= ~sel_q;
            if (sel_q) state_q <= S_DIVI;
          end
        end
        S_DIVI: begin
          cnt_q   <= CNT_W'(QW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) state_q <= S_STORE;
          else cnt_q <= cnt_q - 1'b1;
        end
        S_STORE: begin
          cnt_q <= '0;
          sel_q <= 1'b0;
          if (comp_q == ssf_pkg::LAST_COMP) begin
            comp_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= S_SQ2;
          end
        end
        S_EMIT:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/ssf_dp.sv
// Datapath: configuration, lattice position, trigonometry, sums, squares and divider.
module ssf_dp #(
  parameter int unsigned MAX_SIDE   = 64,
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned SPIN_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  ssf_pkg::cmd_t                     cmd_i,
  output ssf_pkg::sts_t                     sts_o,
  input  logic [3*SPIN_BITS-1:0]            spin_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [3*ssf_pkg::SF_W-1:0]        out_data_o
);

  localparam int unsigned LW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned PW    = $clog2(MAX_SIDE);
  localparam int unsigned SUM_W = SPIN_BITS + 16 + 3 * $clog2(MAX_SIDE);
  localparam int unsigned MW    = 2 * SUM_W;
  localparam int unsigned QW    = MW - 44;
  localparam int unsigned NW    = 3 * LW;
  localparam int unsigned CW    = (QW > ssf_pkg::SF_W) ? QW : ssf_pkg::SF_W;

  logic                            dim_q;
  logic [ssf_pkg::LEN_W-1:0]       len_x_q, len_y_q, len_z_q;
  logic [ssf_pkg::STEP_W-1:0]      step_x_q, step_y_q, step_z_q;

  logic [PW-1:0]                   pos_x_q, pos_y_q, pos_z_q;
  logic [PHASE_BITS-1:0]           site_q, row_q, plane_q;
  logic signed [SUM_W-1:0]         sum_c_q [3];
  logic signed [SUM_W-1:0]         sum_s_q [3];
  logic                            out_valid_q;

  logic signed [SPIN_BITS-1:0]     spin_q [3];
  logic [1:0]                      quad_q;
  logic [15:0]                     u_q;
  logic [30:0]                     x_q, x2_q;
  logic [31:0]                     p_q;
  logic [15:0]                     sa_q, sb_q;
  logic [NW-1:0]                   n_q;
  logic [MW-1:0]                   m_q;
  logic [QW-1:0]                   d_q;
  logic [NW-1:0]                   r_q;
  logic [ssf_pkg::SF_W-1:0]        res_q [3];

  logic [LW-1:0]                   lx, ly, lz;
  logic                            x_more, y_more, z_more;
  logic [31:0]                     sx32, sy32, sz32;
  logic [PHASE_BITS-1:0]           sx, sy, sz;
  logic [15:0]                     u_w;
  logic [31:0]                     mul_a, mul_b;
  logic [63:0]                     prod;
  logic [33:0]                     fin_s;
  logic [19:0]                     fin_r;
  logic [15:0]                     fin_v;
  logic signed [SPIN_BITS-1:0]     sp_sel;
  logic [SPIN_BITS-1:0]            sp_mag;
  logic [15:0]                     trig_mag;
  logic                            trig_neg;
  logic                            term_neg;
  logic [SUM_W-1:0]                term;
  logic signed [SUM_W-1:0]         sum_sel;
  logic [SUM_W-1:0]                sum_mag;
  logic [63:0]                     a64;
  logic [127:0]                    sq_term;
  logic [MW-1:0]                   m_base;
  logic [NW:0]                     trial;
  logic                            ge;
  logic [CW-1:0]                   dq_ext;
  logic [ssf_pkg::SF_W-1:0]        sf_sat;

  function automatic logic [LW-1:0] eff_len(input logic [ssf_pkg::LEN_W-1:0] l);
    if (l == '0) return LW'(1);
    if (int'(l) > int'(MAX_SIDE)) return LW'(MAX_SIDE);
    return LW'(l);
  endfunction

  assign lx = eff_len(len_x_q);
  assign ly = eff_len(len_y_q);
  assign lz = eff_len(len_z_q);

  assign x_more = ((LW+1)'(pos_x_q) + 1'b1) < (LW+1)'(lx);
  assign y_more = ((LW+1)'(pos_y_q) + 1'b1) < (LW+1)'(ly);
  assign z_more = ((LW+1)'(pos_z_q) + 1'b1) < (LW+1)'(lz);

  assign sts_o.frame_end = !x_more && !y_more && !(dim_q && z_more);
  assign sts_o.out_busy  = out_valid_q;

  assign sx32 = 32'(step_x_q);
  assign sy32 = 32'(step_y_q);
  assign sz32 = 32'(step_z_q);
  assign sx   = sx32[PHASE_BITS-1:0];
  assign sy   = sy32[PHASE_BITS-1:0];
  assign sz   = sz32[PHASE_BITS-1:0];

  generate
    if (PHASE_BITS >= 18) begin : g_u_shr
      assign u_w = 16'(site_q[PHASE_BITS-3:0] >> (PHASE_BITS - 18));
    end else begin : g_u_shl
      logic [31:0] frac_sh;
      assign frac_sh = 32'(site_q[PHASE_BITS-3:0]) << (18 - PHASE_BITS);
      assign u_w = frac_sh[15:0];
    end
  endgenerate

  always_comb begin
    case (cmd_i.comp)
      2'd1:    begin sp_sel = spin_q[1]; sum_sel = cmd_i.sel ? sum_s_q[1] : sum_c_q[1]; end
      2'd2:    begin sp_sel = spin_q[2]; sum_sel = cmd_i.sel ? sum_s_q[2] : sum_c_q[2]; end
      default: begin sp_sel = spin_q[0]; sum_sel = cmd_i.sel ? sum_s_q[0] : sum_c_q[0]; end
    endcase
  end

  assign sp_mag  = sp_sel[SPIN_BITS-1] ? (~sp_sel + 1'b1) : sp_sel;
  assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
  assign a64     = 64'(sum_mag);

  always_comb begin
    if (cmd_i.sel) begin
      trig_mag = quad_q[0] ? sb_q : sa_q;
      trig_neg = quad_q[1];
    end else begin
      trig_mag = quad_q[0] ? sa_q : sb_q;
      trig_neg = quad_q[0] ^ quad_q[1];
    end
  end

  always_comb begin
    case (cmd_i.op)
      ssf_pkg::OP_SQ:    begin mul_a = 32'(x_q);  mul_b = 32'(x_q); end
      ssf_pkg::OP_HORN:  begin mul_a = 32'(x2_q); mul_b = p_q; end
      ssf_pkg::OP_FIN:   begin mul_a = 32'(x_q);  mul_b = p_q; end
      ssf_pkg::OP_MAC:   begin mul_a = 32'(sp_mag); mul_b = 32'(trig_mag); end
      ssf_pkg::OP_N1:    begin mul_a = 32'(lx); mul_b = 32'(ly); end
      ssf_pkg::OP_N2:    begin mul_a = 32'(n_q); mul_b = dim_q ? 32'(lz) : 32'd1; end
      ssf_pkg::OP_SQLL:  begin mul_a = a64[31:0];  mul_b = a64[31:0]; end
      ssf_pkg::OP_SQMID: begin mul_a = a64[63:32]; mul_b = a64[31:0]; end
      ssf_pkg::OP_SQHH:  begin mul_a = a64[63:32]; mul_b = a64[63:32]; end
      default:           begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign fin_s = prod[63:30];
  assign fin_r = 20'((fin_s + 34'd16384) >> 15);
  assign fin_v = (fin_r > 20'd32768) ? 16'd32768 : fin_r[15:0];

  assign term_neg = sp_sel[SPIN_BITS-1] ^ trig_neg;
  assign term     = prod[SUM_W-1:0];

  always_comb begin
    case (cmd_i.op)
      ssf_pkg::OP_SQMID: sq_term = 128'(prod) << 33;
      ssf_pkg::OP_SQHH:  sq_term = 128'(prod) << 64;
      default:           sq_term = 128'(prod);
    endcase
  end
  assign m_base = (cmd_i.op == ssf_pkg::OP_SQLL && !cmd_i.sel) ? '0 : m_q;

  assign trial = {r_q, d_q[QW-1]};
  assign ge    = trial >= {1'b0, n_q};

  assign dq_ext = CW'(d_q);
  assign sf_sat = (dq_ext > CW'(ssf_pkg::SF_LIMIT)) ? ssf_pkg::SF_LIMIT
                                                     : ssf_pkg::SF_W'(dq_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q       <= 1'b0;
      len_x_q     <= 7'd16;
      len_y_q     <= 7'd16;
      len_z_q     <= 7'd16;
      step_x_q    <= '0;
      step_y_q    <= '0;
      step_z_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      site_q      <= '0;
      row_q       <= '0;
      plane_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_c_q[k] <= '0;
        sum_s_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ssf_pkg::CFG_DIM:    dim_q    <= cfg_data_i[0];
          ssf_pkg::CFG_LEN_X:  len_x_q  <= cfg_data_i[ssf_pkg::LEN_W-1:0];
          ssf_pkg::CFG_LEN_Y:  len_y_q  <= cfg_data_i[ssf_pkg::LEN_W-1:0];
          ssf_pkg::CFG_LEN_Z:  len_z_q  <= cfg_data_i[ssf_pkg::LEN_W-1:0];
          ssf_pkg::CFG_STEP_X: step_x_q <= cfg_data_i;
          ssf_pkg::CFG_STEP_Y: step_y_q <= cfg_data_i;
          ssf_pkg::CFG_STEP_Z: step_z_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        ssf_pkg::OP_MAC: begin
          for (int k = 0; k < 3; k++) begin
            if (cmd_i.comp == 2'(k)) begin
              if (cmd_i.sel)
                sum_s_q[k] <= term_neg ? sum_s_q[k] - term : sum_s_q[k] + term;
              else
                sum_c_q[k] <= term_neg ? sum_c_q[k] - term : sum_c_q[k] + term;
            end
          end
        end
        ssf_pkg::OP_ADV: begin
          if (x_more) begin
            pos_x_q <= pos_x_q + 1'b1;
            site_q  <= site_q + sx;
          end else begin
            pos_x_q <= '0;
            if (y_more) begin
              pos_y_q <= pos_y_q + 1'b1;
              row_q   <= row_q + sy;
              site_q  <= row_q + sy;
            end else begin
              pos_y_q <= '0;
              if (dim_q && z_more) begin
                pos_z_q <= pos_z_q + 1'b1;
                plane_q <= plane_q + sz;
                row_q   <= plane_q + sz;
                site_q  <= plane_q + sz;
              end else begin
                pos_z_q <= '0;
                plane_q <= '0;
                row_q   <= '0;
                site_q  <= '0;
              end
            end
          end
        end
        ssf_pkg::OP_EMIT: begin
          out_valid_q <= 1'b1;
          for (int k = 0; k < 3; k++) begin
            sum_c_q[k] <= '0;
            sum_s_q[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ssf_pkg::OP_LOAD: begin
        for (int k = 0; k < 3; k++) spin_q[k] <= spin_i[k*SPIN_BITS +: SPIN_BITS];
        quad_q <= site_q[PHASE_BITS-1:PHASE_BITS-2];
        u_q    <= u_w;
        x_q    <= {1'b0, u_w, 14'd0};
      end
      ssf_pkg::OP_SQ: begin
        x2_q <= prod[60:30];
        p_q  <= ssf_pkg::poly_coef(3'd4);
      end
      ssf_pkg::OP_HORN: p_q <= ssf_pkg::poly_coef(cmd_i.coef) - prod[61:30];
      ssf_pkg::OP_FIN: begin
        if (cmd_i.pass) begin
          sb_q <= fin_v;
        end else begin
          sa_q <= fin_v;
          x_q  <= {ssf_pkg::QTR_TURN - 17'(u_q), 14'd0};
        end
      end
      ssf_pkg::OP_N1, ssf_pkg::OP_N2: n_q <= prod[NW-1:0];
      ssf_pkg::OP_SQLL, ssf_pkg::OP_SQMID, ssf_pkg::OP_SQHH:
        m_q <= m_base + sq_term[MW-1:0];
      ssf_pkg::OP_DIVI: begin
        d_q <= m_q[MW-1:44];
        r_q <= '0;
      end
      ssf_pkg::OP_DIVS: begin
        r_q <= ge ? NW'(trial - {1'b0, n_q}) : trial[NW-1:0];
        d_q <= {d_q[QW-2:0], ge};
      end
      ssf_pkg::OP_STORE: begin
        for (int k = 0; k < 3; k++) if (cmd_i.comp == 2'(k)) res_q[k] <= sf_sat;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {res_q[2], res_q[1], res_q[0]};

endmodule

### hdl/spin_structure_factor.sv
// Spin structure factor at one wavevector: a sequencer and a datapath.
//
// Spins enter on the slave stream, one lattice site per beat, in raster order
// (x fastest, then y, then z in 3D mode). The configuration channel is always
// ready and writes one register per beat; the user is to write it only while the
// block idles, which the block itself does not enforce. Per site, the block takes
// the beat, runs two quarter-sine polynomial evaluations of six steps each and six
// spin-times-trig accumulations, all on one shared 32 by 32 multiplier, and then
// advances the position; it takes no new site until then. After the last site of
// a lattice, the block squares the sums and divides by the site count, one
// quotient bit per cycle; then one result beat appears on the master stream.
// The next lattice's first site is accepted as soon as the result is loaded
// into the output register. If the receiver stalls, the result is held and the
// block keeps taking sites until it reaches the end of the following lattice,
// where it waits for the pending beat to leave.
// Reset clears the position, phases and sums and loads the register defaults.
module spin_structure_factor #(
  parameter int unsigned MAX_SIDE   = 64,
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned SPIN_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // spin_x, spin_y, spin_z from the lowest bit up, zero padded.
  input  logic [((3*SPIN_BITS+7)/8)*8-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sf_x, sf_y, sf_z from the lowest bit up, zero padded.
  output logic [ssf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  `include "spin_structure_factor_defines.svh"

  localparam int unsigned SUM_W   = SPIN_BITS + 16 + 3 * $clog2(MAX_SIDE);
  localparam int unsigned QW      = 2 * SUM_W - 44;
  localparam int unsigned OUT_PAD = ssf_pkg::OUT_TDATA_W - 3 * ssf_pkg::SF_W;

  ssf_pkg::cmd_t                  cmd;
  ssf_pkg::sts_t                  sts;
  logic [3*ssf_pkg::SF_W-1:0]     out_data;

  assign cfg_ready_o = 1'b1;

  ssf_ctrl #(
    .QW (QW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssf_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PHASE_BITS (PHASE_BITS),
    .SPIN_BITS  (SPIN_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .spin_i      (s_axis_tdata[3*SPIN_BITS-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_data};

  `SSF_ASSERT_NOW(a_emit_free, cmd.op == ssf_pkg::OP_EMIT, !sts.out_busy)
  `SSF_ASSERT_NXT(a_emit_shows, cmd.op == ssf_pkg::OP_EMIT, m_axis_tvalid)
  `SSF_ASSERT_NXT(a_one_site, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

### tb/spin_structure_factor_tb.sv
// Self-checking testbench of the spin structure factor block with random stimulus.
`timescale 1ns / 100ps

module spin_structure_factor_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SITE_TARGET = 1100;
  localparam int unsigned DRAIN_WAIT = 300;
  localparam int unsigned SF_W = ssf_pkg::SF_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [ssf_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [ssf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic cfg_ready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ssf_pkg::OUT_TDATA_W-1:0] m_tdata;

  logic [47:0] spin_q[$];
  logic [3*SF_W-1:0] sf_expected_q[$];
  int unsigned sites_issued = 0;
  int unsigned mismatches = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit send_gapless = 1'b0;
  bit recv_gapless = 1'b0;

  // Predictor state.
  bit lat_3d;
  bit [6:0] side_x, side_y, side_z;
  bit [23:0] kx, ky, kz;
  int unsigned at_x, at_y, at_z;
  bit [23:0] ph_site, ph_row, ph_plane;
  longint acc_cos[3], acc_sin[3];

  always #6 clk = ~clk;

  spin_structure_factor u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  function automatic bit [16:0] quarter_sin(input bit [16:0] v);
    bit [63:0] x, x2, p, s;
    x = 64'(v) << 14;
    x2 = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5026995 - ((x2 * p) >> 30);
    p = 64'd85569274 - ((x2 * p) >> 30);
    p = 64'd693598668 - ((x2 * p) >> 30);
    p = 64'd1686629713 - ((x2 * p) >> 30);
    s = (x * p) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return s[16:0];
  endfunction

  function automatic int unsigned side_of(input bit [6:0] len);
    if (len == 0) return 1;
    if (len > 64) return 64;
    return 32'(len);
  endfunction

  function automatic bit [127:0] square_of(input longint v);
    bit [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    return {64'b0, mag} * {64'b0, mag};
  endfunction

  function automatic void clear_lattice();
    at_x = 0; at_y = 0; at_z = 0;
    ph_site = '0; ph_row = '0; ph_plane = '0;
    for (int k = 0; k < 3; k++) begin
      acc_cos[k] = 0;
      acc_sin[k] = 0;
    end
  endfunction

  // Accumulates one site; returns 1 with the structure factors when the lattice closes.
  function automatic bit accumulate_site(input logic [47:0] d, output logic [3*SF_W-1:0] sf);
    int unsigned lx, ly, lz;
    int c, s, a, b;
    bit [15:0] u;
    longint sp, n;
    bit [127:0] m, q;
    lx = side_of(side_x);
    ly = side_of(side_y);
    lz = side_of(side_z);
    sf = '0;
    u = ph_site[21:6];
    a = quarter_sin({1'b0, u});
    b = quarter_sin(17'd65536 - {1'b0, u});
    case (ph_site[23:22])
      2'd0: begin c = b; s = a; end
      2'd1: begin c = -a; s = b; end
      2'd2: begin c = -b; s = -a; end
      default: begin c = a; s = -b; end
    endcase
    for (int k = 0; k < 3; k++) begin
      sp = longint'($signed(d[k*16 +: 16]));
      acc_cos[k] += sp * longint'(c);
      acc_sin[k] += sp * longint'(s);
    end
    if (at_x + 1 < lx) begin
      at_x++;
      ph_site = ph_site + kx;
      return 1'b0;
    end
    at_x = 0;
    if (at_y + 1 < ly) begin
      at_y++;
      ph_row = ph_row + ky;
      ph_site = ph_row;
      return 1'b0;
    end
    at_y = 0;
    if (lat_3d && at_z + 1 < lz) begin
      at_z++;
      ph_plane = ph_plane + kz;
      ph_row = ph_plane;
      ph_site = ph_plane;
      return 1'b0;
    end
    n = longint'(lx) * ly * (lat_3d ? lz : 1);
    for (int k = 0; k < 3; k++) begin
      m = square_of(acc_cos[k]) + square_of(acc_sin[k]);
      q = (m >> 44) / 128'(n);
      if (q > 128'(ssf_pkg::SF_LIMIT)) q = 128'(ssf_pkg::SF_LIMIT);
      sf[k*SF_W +: SF_W] = q[SF_W-1:0];
    end
    clear_lattice();
    return 1'b1;
  endfunction

  task automatic write_reg(input ssf_pkg::cfg_idx_e idx, input bit [23:0] val);
    case (idx)
      ssf_pkg::CFG_DIM: lat_3d = val[0];
      ssf_pkg::CFG_LEN_X: side_x = val[6:0];
      ssf_pkg::CFG_LEN_Y: side_y = val[6:0];
      ssf_pkg::CFG_LEN_Z: side_z = val[6:0];
      ssf_pkg::CFG_STEP_X: kx = val;
      ssf_pkg::CFG_STEP_Y: ky = val;
      default: kz = val;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_lattice(input bit dim3, input bit [6:0] lx, input bit [6:0] ly,
                              input bit [6:0] lz, input bit [23:0] sx, input bit [23:0] sy,
                              input bit [23:0] sz);
    write_reg(ssf_pkg::CFG_DIM, {23'b0, dim3});
    write_reg(ssf_pkg::CFG_LEN_X, {17'b0, lx});
    write_reg(ssf_pkg::CFG_LEN_Y, {17'b0, ly});
    write_reg(ssf_pkg::CFG_LEN_Z, {17'b0, lz});
    write_reg(ssf_pkg::CFG_STEP_X, sx);
    write_reg(ssf_pkg::CFG_STEP_Y, sy);
    write_reg(ssf_pkg::CFG_STEP_Z, sz);
  endtask

  task automatic queue_site(input logic [47:0] d);
    logic [3*SF_W-1:0] sf;
    if (accumulate_site(d, sf)) sf_expected_q.push_back(sf);
    spin_q.push_back(d);
    sites_issued++;
  endtask

  // Holds the sender until every queued beat has left and every result has come back.
  task automatic drain();
    while (spin_q.size() != 0 || s_tvalid) @(posedge clk);
    while (sf_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic bit [23:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h400000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] pick_spin();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (spin_q.size() > 0) begin
        s_tdata <= spin_q.pop_front();
        s_tvalid <= 1'b1;
        send_gap <= send_gapless ? 0 : $urandom_range(0, 6);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    logic [3*SF_W-1:0] want;
    int unsigned st;
    if (!rst_n) begin
      m_tready <= 1'b0;
      recv_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      if (sf_expected_q.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("Unexpected result beat: %h", m_tdata[3*SF_W-1:0]);
        mismatches++;
      end else begin
        want = sf_expected_q.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (m_tdata[k*SF_W +: SF_W] !== want[k*SF_W +: SF_W]) begin
            failures++;
            if (mismatches < 10)
              $display("Field sf[%0d] mismatch: expected %0d, got %0d", k,
                       want[k*SF_W +: SF_W], m_tdata[k*SF_W +: SF_W]);
            mismatches++;
          end
        end
      end
      st = recv_gapless ? 0 : $urandom_range(0, 6);
      if (st > 0) begin
        m_tready <= 1'b0;
        recv_stall <= st - 1;
      end
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("spin_structure_factor verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned lattices, extra, sites, big_axis;
    bit [6:0] lx, ly, lz;
    bit dim3, fixed_spin;
    logic [47:0] spin_word;
    lat_3d = 1'b0;
    side_x = 7'd16; side_y = 7'd16; side_z = 7'd16;
    kx = '0; ky = '0; kz = '0;
    clear_lattice();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Single-site lattices with extreme spins.
    load_lattice(1'b0, 7'd1, 7'd1, 7'd1, 24'h0, 24'h0, 24'h0);
    queue_site({16'h0000, 16'h8000, 16'h7FFF});
    queue_site({16'h8000, 16'h8000, 16'h8000});
    queue_site({16'h7FFF, 16'h7FFF, 16'h7FFF});
    queue_site({16'h0000, 16'h0000, 16'h0000});
    queue_site({16'h5555, 16'hFFFF, 16'h0001});
    queue_site({16'hAAAA, 16'h0001, 16'hFFFF});
    drain();

    // Zero length acts as one; full and wrapped steps in a small 3D lattice.
    load_lattice(1'b1, 7'd0, 7'd2, 7'd2, 24'hFFFFFF, 24'h400000, 24'hC00000);
    for (int i = 0; i < 8; i++) queue_site({pick_spin(), pick_spin(), pick_spin()});
    drain();

    // Three sites into a 2D lattice, then a switch to 3D mid lattice.
    load_lattice(1'b0, 7'd2, 7'd2, 7'd3, 24'h123456, 24'h654321, 24'h0ABCDE);
    for (int i = 0; i < 3; i++) queue_site({pick_spin(), pick_spin(), pick_spin()});
    drain();
    load_lattice(1'b1, 7'd2, 7'd2, 7'd3, 24'h123456, 24'h654321, 24'h0ABCDE);
    for (int i = 0; i < 9; i++) queue_site({pick_spin(), pick_spin(), pick_spin()});
    drain();

    while (sites_issued < SITE_TARGET) begin
      dim3 = 1'($urandom_range(0, 1));
      lx = 7'($urandom_range(0, 5));
      ly = 7'($urandom_range(0, 5));
      lz = 7'($urandom_range(0, 4));
      if ($urandom_range(0, 9) == 0) begin
        big_axis = $urandom_range(0, 2);
        lx = (big_axis == 0) ? (($urandom_range(0, 1) == 1) ? 7'd64 : 7'd127) : 7'd1;
        ly = (big_axis == 1) ? (($urandom_range(0, 1) == 1) ? 7'd64 : 7'd65) : 7'd1;
        lz = (big_axis == 2) ? 7'd64 : 7'd1;
      end
      load_lattice(dim3, lx, ly, lz, pick_step(), pick_step(), pick_step());
      send_gapless = ($urandom_range(0, 3) == 0);
      recv_gapless = ($urandom_range(0, 3) == 0);
      sites = side_of(lx) * side_of(ly) * (dim3 ? side_of(lz) : 1);
      lattices = $urandom_range(1, 3);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sites) : 0;
      fixed_spin = ($urandom_range(0, 2) == 0);
      spin_word = {pick_spin(), pick_spin(), pick_spin()};
      for (int i = 0; i < lattices * sites + extra; i++)
        queue_site(fixed_spin ? spin_word : {pick_spin(), pick_spin(), pick_spin()});
      drain();
    end

    if (failures == 0)
      $display("spin_structure_factor verification clean");
    else
      $display("spin_structure_factor verification failed");
    $finish;
  end

endmodule
